@@ hdl/smps_pkg.sv @@
package smps_pkg;

	localparam int FUNC_W     = 3;
	localparam int ERR_W      = 2;
	localparam int UM_W       = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	localparam int UM_PER_MM  = 1000;
	localparam int MUL_BITS   = 10;

	localparam int ON_TICKS_RST  = 5000;
	localparam int OFF_TICKS_RST = 5000;
	localparam int UM_RST        = 40;
	localparam int BASE_RST      = 100;

	localparam logic [FUNC_W-1:0] FUNC_HOME_UP   = 3'd1;
	localparam logic [FUNC_W-1:0] FUNC_HOME_DOWN = 3'd2;
	localparam logic [FUNC_W-1:0] FUNC_MOVE      = 3'd3;
	localparam logic [FUNC_W-1:0] FUNC_RESTART   = 3'd4;

	localparam logic [ERR_W-1:0] ERR_NONE  = 2'd0;
	localparam logic [ERR_W-1:0] ERR_LIMIT = 2'd1;
	localparam logic [ERR_W-1:0] ERR_BUSY  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_ON_TICKS  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OFF_TICKS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_UM        = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BASE      = 2'd3;

	typedef enum logic [1:0] {
		MODE_IDLE = 2'd0,
		MODE_UP   = 2'd1,
		MODE_DOWN = 2'd2,
		MODE_MOVE = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		CS_RUN      = 2'd0,
		CS_DIV_LOAD = 2'd1,
		CS_DIV_WAIT = 2'd2
	} ctrl_state_t;

	typedef struct packed {
		logic take;
		logic div_start;
		logic finish;
	} dp_cmd_t;

	typedef struct packed {
		logic move_start;
		logic div_done;
	} dp_stat_t;

endpackage

@@ hdl/smps_if.sv @@
interface smps_cmd_if import smps_pkg::*; #(
	parameter int HEIGHT_BITS = 16
);
	logic                   valid;
	logic                   ready;
	logic [FUNC_W-1:0]      func;
	logic [HEIGHT_BITS-1:0] target_mm;
	logic                   high_limit;
	logic                   low_limit;

	modport source (output valid, func, target_mm, high_limit, low_limit, input ready);
	modport sink (input valid, func, target_mm, high_limit, low_limit, output ready);
endinterface

interface smps_rsp_if import smps_pkg::*; #(
	parameter int PULSE_BITS = 20
);
	logic                  valid;
	logic                  ready;
	logic                  step_up;
	logic                  step_down;
	logic                  driver_off;
	logic                  busy_res;
	logic                  done_res;
	logic [ERR_W-1:0]      error_code;
	logic [PULSE_BITS-1:0] pulses_issued;

	modport source (output valid, step_up, step_down, driver_off, busy_res, done_res,
		error_code, pulses_issued, input ready);
	modport sink (input valid, step_up, step_down, driver_off, busy_res, done_res,
		error_code, pulses_issued, output ready);
endinterface

interface smps_cfg_if import smps_pkg::*;;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

@@ hdl/smps_div.sv @@
module smps_div import smps_pkg::*; #(
	parameter int DW = 26
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [DW-1:0]   dividend,
	input  logic [UM_W-1:0] divisor,
	output logic            done,
	output logic [DW-1:0]   quotient
);

	localparam int CW = $clog2(DW + 1);

	logic [CW-1:0]   cnt_q;
	logic            busy_q;
	logic            done_q;
	logic [UM_W-1:0] rem_q;
	logic [UM_W-1:0] den_q;
	logic [DW-1:0]   quo_q;
	logic [UM_W:0]   trial;
	logic [UM_W:0]   diff;
	logic            ge;

	assign trial = {rem_q, quo_q[DW-1]};
	assign ge    = trial >= {1'b0, den_q};
	assign diff  = ge ? (trial - {1'b0, den_q}) : trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= diff[UM_W-1:0];
			quo_q <= {quo_q[DW-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

@@ hdl/smps_ctrl.sv @@
module smps_ctrl import smps_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  logic     out_ready,
	input  dp_stat_t stat,
	output logic     in_ready,
	output logic     out_valid,
	output dp_cmd_t  cmd
);

	ctrl_state_t state_q, state_n;
	logic        res_valid_q;
	logic        out_free;

	assign out_free = !res_valid_q || out_ready;

	always_comb begin
		state_n = state_q;
		case (state_q)
			CS_RUN: begin
				if (in_valid && out_free && stat.move_start) begin
					state_n = CS_DIV_LOAD;
				end
			end
			CS_DIV_LOAD: begin
				state_n = CS_DIV_WAIT;
			end
			CS_DIV_WAIT: begin
				if (stat.div_done) begin
					state_n = CS_RUN;
				end
			end
			default: begin
				state_n = CS_RUN;
			end
		endcase
	end

	always_comb begin
		cmd.take      = 1'b0;
		cmd.div_start = 1'b0;
		cmd.finish    = 1'b0;
		in_ready      = 1'b0;
		case (state_q)
			CS_RUN: begin
				in_ready = out_free;
				cmd.take = in_valid && out_free;
			end
			CS_DIV_LOAD: begin
				cmd.div_start = 1'b1;
			end
			CS_DIV_WAIT: begin
				cmd.finish = stat.div_done;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= CS_RUN;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if ((cmd.take && !stat.move_start) || cmd.finish) begin
				res_valid_q <= 1'b1;
			end else if (out_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = res_valid_q;

endmodule

@@ hdl/smps_dp.sv @@
module smps_dp import smps_pkg::*; #(
	parameter int TICK_BITS   = 24,
	parameter int PULSE_BITS  = 20,
	parameter int HEIGHT_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  dp_cmd_t                cmd,
	output dp_stat_t               stat,
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic [FUNC_W-1:0]      func,
	input  logic [HEIGHT_BITS-1:0] target_mm,
	input  logic                   high_limit,
	input  logic                   low_limit,
	output logic                   step_up,
	output logic                   step_down,
	output logic                   driver_off,
	output logic                   busy_res,
	output logic                   done_res,
	output logic [ERR_W-1:0]       error_code,
	output logic [PULSE_BITS-1:0]  pulses_issued
);

	localparam int DW  = HEIGHT_BITS + MUL_BITS;
	localparam int QW  = (DW > PULSE_BITS) ? DW : PULSE_BITS;
	localparam int PW1 = PULSE_BITS + 1;

	logic [TICK_BITS-1:0]   on_q, off_q;
	logic [UM_W-1:0]        um_q;
	logic [HEIGHT_BITS-1:0] base_q;

	mode_t                  mode_q, mode_n;
	logic                   phase_q, phase_n;
	logic [TICK_BITS-1:0]   ticks_q, ticks_n, tick_inc;
	logic [PULSE_BITS-1:0]  done_q, done_n, done_inc;
	logic [PULSE_BITS-1:0]  goal_q, goal_n;
	logic [HEIGHT_BITS-1:0] prev_q, prev_n;
	logic [HEIGHT_BITS-1:0] target_q, target_n;
	logic                   upper_q, upper_n;
	logic                   fin_done;
	logic [ERR_W-1:0]       fin_err;
	logic                   finished;
	logic                   limit_short;

	logic [HEIGHT_BITS-1:0] diff;
	logic [DW-1:0]          prod_s1;
	logic [UM_W-1:0]        divisor;
	logic                   div_done;
	logic [DW-1:0]          quotient;
	logic [QW-1:0]          quo_ext;
	logic [PULSE_BITS-1:0]  pulse_max;
	logic [PULSE_BITS-1:0]  goal_sat;
	logic                   is_cmd;

	logic                   res_up_q, res_down_q, res_off_q, res_busy_q, res_done_q;
	logic [ERR_W-1:0]       res_err_q;
	logic [PULSE_BITS-1:0]  res_pulses_q;

	assign pulse_max   = '1;
	assign is_cmd      = func inside {[FUNC_HOME_UP:FUNC_RESTART]};
	assign tick_inc    = ticks_q + TICK_BITS'(1);
	assign done_inc    = (done_q != pulse_max) ? done_q + PULSE_BITS'(1) : done_q;
	assign limit_short = ({1'b0, done_inc} + PW1'(1)) < {1'b0, goal_q};
	assign diff        = (target_mm > prev_q) ? target_mm - prev_q : prev_q - target_mm;
	assign divisor     = (um_q == '0) ? UM_W'(1) : um_q;
	assign quo_ext     = QW'(quotient);
	assign goal_sat    = (quo_ext > QW'(pulse_max)) ? pulse_max : quo_ext[PULSE_BITS-1:0];

	assign stat.move_start = (func == FUNC_MOVE) && (mode_q == MODE_IDLE);
	assign stat.div_done   = div_done;

	smps_div #(
		.DW(DW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (prod_s1),
		.divisor  (divisor),
		.done     (div_done),
		.quotient (quotient)
	);

	always_comb begin
		mode_n   = mode_q;
		phase_n  = phase_q;
		ticks_n  = ticks_q;
		done_n   = done_q;
		goal_n   = goal_q;
		prev_n   = prev_q;
		target_n = target_q;
		upper_n  = upper_q;
		fin_done = 1'b0;
		fin_err  = ERR_NONE;
		finished = 1'b0;
		if (cmd.finish) begin
			goal_n = goal_sat;
			done_n = '0;
			if (goal_sat == '0) begin
				prev_n   = target_q;
				fin_done = 1'b1;
			end else begin
				mode_n  = MODE_MOVE;
				phase_n = 1'b1;
				ticks_n = '0;
			end
		end else if (is_cmd) begin
			if (mode_q != MODE_IDLE) begin
				fin_err = ERR_BUSY;
			end else begin
				case (func)
					FUNC_HOME_UP: begin
						prev_n = base_q;
						done_n = '0;
						if (high_limit) begin
							fin_done = 1'b1;
						end else begin
							mode_n  = MODE_UP;
							phase_n = 1'b1;
							ticks_n = '0;
						end
					end
					FUNC_HOME_DOWN: begin
						mode_n  = MODE_DOWN;
						phase_n = 1'b1;
						ticks_n = '0;
						done_n  = '0;
					end
					FUNC_MOVE: begin
						upper_n  = 1'b0;
						target_n = target_mm;
						done_n   = '0;
					end
					default: begin
						prev_n = base_q;
					end
				endcase
			end
		end else if (mode_q != MODE_IDLE) begin
			if (phase_q) begin
				if (tick_inc >= on_q) begin
					phase_n = 1'b0;
					ticks_n = '0;
				end else begin
					ticks_n = tick_inc;
				end
			end else if (tick_inc >= off_q) begin
				ticks_n = '0;
				done_n  = done_inc;
				case (mode_q)
					MODE_UP: begin
						finished = high_limit;
					end
					MODE_DOWN: begin
						finished = low_limit;
					end
					default: begin
						upper_n  = high_limit;
						finished = high_limit || (done_inc >= goal_q);
						if (finished) begin
							if (high_limit && limit_short) begin
								fin_err = ERR_LIMIT;
								prev_n  = base_q;
							end else begin
								prev_n = target_q;
							end
						end
					end
				endcase
				if (finished) begin
					mode_n   = MODE_IDLE;
					phase_n  = 1'b0;
					fin_done = 1'b1;
				end else begin
					phase_n = 1'b1;
				end
			end else begin
				ticks_n = tick_inc;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			on_q     <= TICK_BITS'(ON_TICKS_RST);
			off_q    <= TICK_BITS'(OFF_TICKS_RST);
			um_q     <= UM_W'(UM_RST);
			base_q   <= HEIGHT_BITS'(BASE_RST);
			mode_q   <= MODE_IDLE;
			phase_q  <= 1'b0;
			ticks_q  <= '0;
			done_q   <= '0;
			goal_q   <= '0;
			prev_q   <= HEIGHT_BITS'(BASE_RST);
			target_q <= '0;
			upper_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_ON_TICKS:  on_q   <= cfg_data[TICK_BITS-1:0];
					REG_OFF_TICKS: off_q  <= cfg_data[TICK_BITS-1:0];
					REG_UM:        um_q   <= cfg_data[UM_W-1:0];
					REG_BASE:      base_q <= cfg_data[HEIGHT_BITS-1:0];
					default:       um_q   <= um_q;
				endcase
			end
			if (cmd.take || cmd.finish) begin
				mode_q   <= mode_n;
				phase_q  <= phase_n;
				ticks_q  <= ticks_n;
				done_q   <= done_n;
				goal_q   <= goal_n;
				prev_q   <= prev_n;
				target_q <= target_n;
				upper_q  <= upper_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			prod_s1 <= DW'(diff) * DW'(UM_PER_MM);
		end
		if (cmd.take || cmd.finish) begin
			res_up_q     <= phase_n && ((mode_n == MODE_UP) || (mode_n == MODE_MOVE));
			res_down_q   <= phase_n && (mode_n == MODE_DOWN);
			res_off_q    <= mode_n == MODE_IDLE;
			res_busy_q   <= mode_n != MODE_IDLE;
			res_done_q   <= fin_done;
			res_err_q    <= fin_err;
			res_pulses_q <= done_n;
		end
	end

	assign step_up       = res_up_q;
	assign step_down     = res_down_q;
	assign driver_off    = res_off_q;
	assign busy_res      = res_busy_q;
	assign done_res      = res_done_q;
	assign error_code    = res_err_q;
	assign pulses_issued = res_pulses_q;

endmodule

@@ hdl/stepper_mast_pulse_sequencer.sv @@
// Step pulse sequencer for one stepper axis of a sensor mast.
// Requests arrive on cmd: a tick that carries the limit switch levels, or a
// command (home up, home down, move to target, restart). Each request yields
// exactly one result on rsp with the step line levels and the motion status.
// The cfg channel writes the timing, travel and base height registers; it is
// always ready and must be written only while no request is in flight, which
// the block itself does not enforce. Ticks, homing commands, restarts and
// commands while busy stream at one per cycle while rsp is not stalled, with
// the result registered and shown in the cycle after acceptance. A move command
// from idle registers the travel product, then computes its pulse goal with a
// one bit per cycle restoring divider; cmd is not ready during that time.
// A single result register separates the two sides: a new request is taken
// while the previous result is being read, and a stalled rsp holds cmd off.
// Reset restores the register defaults, idles the axis and empties the result
// register.
module stepper_mast_pulse_sequencer import smps_pkg::*; #(
	parameter int TICK_BITS   = 24,
	parameter int PULSE_BITS  = 20,
	parameter int HEIGHT_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	smps_cmd_if.sink    cmd,
	smps_rsp_if.source  rsp,
	smps_cfg_if.sink    cfg
);

	dp_cmd_t  dp_cmd;
	dp_stat_t dp_stat;

	assign cfg.ready = 1'b1;

	smps_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (cmd.valid),
		.out_ready (rsp.ready),
		.stat      (dp_stat),
		.in_ready  (cmd.ready),
		.out_valid (rsp.valid),
		.cmd       (dp_cmd)
	);

	smps_dp #(
		.TICK_BITS   (TICK_BITS),
		.PULSE_BITS  (PULSE_BITS),
		.HEIGHT_BITS (HEIGHT_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (dp_cmd),
		.stat          (dp_stat),
		.cfg_we        (cfg.valid),
		.cfg_index     (cfg.index),
		.cfg_data      (cfg.data),
		.func          (cmd.func),
		.target_mm     (cmd.target_mm),
		.high_limit    (cmd.high_limit),
		.low_limit     (cmd.low_limit),
		.step_up       (rsp.step_up),
		.step_down     (rsp.step_down),
		.driver_off    (rsp.driver_off),
		.busy_res      (rsp.busy_res),
		.done_res      (rsp.done_res),
		.error_code    (rsp.error_code),
		.pulses_issued (rsp.pulses_issued)
	);

	a_finish_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		dp_cmd.finish |-> !(rsp.valid && !rsp.ready))
		else $error("move result would overwrite a pending result");

	a_move_holds_input: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.valid && cmd.ready && dp_stat.move_start) |=> !cmd.ready)
		else $error("request taken while pulse goal is being computed");

	a_busy_vs_off: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (rsp.busy_res != rsp.driver_off))
		else $error("busy and driver power-down disagree");

	a_one_direction: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> !(rsp.step_up && rsp.step_down))
		else $error("both step lines high");

endmodule
